// ===== rtl/vctr_pkg.sv =====
// Shared item types and status codes for the value change trace recorder.
`timescale 1ns / 1ps
`default_nettype none

package vctr_pkg;

    // Result status codes
    localparam logic [2:0] ST_STORED    = 3'd0;
    localparam logic [2:0] ST_UNCHANGED = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_REJECT    = 3'd3;
    localparam logic [2:0] ST_DISABLED  = 3'd4;

    // Input modes
    localparam logic MODE_RECORD   = 1'b0;
    localparam logic MODE_REGISTER = 1'b1;

    // Configuration register indexes
    localparam logic REG_ENABLE = 1'b0;

    typedef struct packed {
        logic        mode;
        logic [5:0]  event_id;
        logic [31:0] value;
        logic [63:0] timestamp;
    } cmd_t;

    typedef struct packed {
        logic [2:0] status;
        logic [9:0] slot;
        logic       now_full;
    } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/value_change_trace_recorder_core.sv =====
// Top level: value change trace recorder with trace store and latest-slot table.
// An accepted item passes S_LOOK and S_CMP; its result is registered as it leaves S_CMP.
// Items are not overlapped: a new item is taken only in S_IDLE, as the latest-slot read,
//   store value read and write-back depend on each other, one memory access per cycle each.
// A result waiting on rsp_stall holds the item in its final step until taken.
// Reset: a clearing pass zeroes every latest-slot table entry in turn; cmd_stall
//   is high meanwhile. The trace store is tracked by its fill count and needs no pass.
`timescale 1ns / 1ps
`default_nettype none

module value_change_trace_recorder_core #(
    parameter int DEPTH      = 1024,
    parameter int MAX_ID     = 64,
    parameter int VALUE_BITS = 32
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    // input channel
    input  wire logic           cmd_valid,
    output logic                cmd_stall,
    input  wire vctr_pkg::cmd_t cmd,
    // result channel
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output vctr_pkg::rsp_t      rsp,
    // configuration port
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [2:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW = (MAX_ID > 1) ? $clog2(MAX_ID) : 1;

    typedef struct packed {
        logic [5:0]            id;
        logic [VALUE_BITS-1:0] value;
        logic [63:0]           tstamp;
    } entry_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_CMP
    } state_t;

    state_t           state_reg;
    logic [AW-1:0]    write_count_reg;
    logic [IW-1:0]    clr_idx_reg;
    vctr_pkg::cmd_t   req_reg;
    logic             enable_reg;
    logic             rsp_valid_reg;
    vctr_pkg::rsp_t   rsp_reg;

    // memories and their registered read data
    logic [AW-1:0]    latest_slot_mem [MAX_ID];
    entry_t           store_mem [DEPTH];
    logic [AW-1:0]    ls_rdata_reg;
    entry_t           st_rdata_reg;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    logic cfg_we;
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = 32'd0;
        unique case (paddr[2])
            vctr_pkg::REG_ENABLE: prdata = {31'd0, enable_reg};
            default:              prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
        end
        else if (cfg_we && (paddr[2] == vctr_pkg::REG_ENABLE))
        begin
            enable_reg <= pwdata[0];
        end
    end

    // ------------------------------------------------------------------
    // Item decode and decision
    // ------------------------------------------------------------------
    logic [15:0]           cmd_id_ext;
    logic [15:0]           req_id_ext;
    logic [IW-1:0]         cmd_idx;
    logic [IW-1:0]         req_idx;
    logic [63:0]           val_ext;
    logic [VALUE_BITS-1:0] val_use;
    logic [VALUE_BITS-1:0] prev_val;
    logic                  store_full;
    logic [2:0]            status;
    logic                  do_store;
    logic                  finish;
    logic [AW-1:0]         count_after;
    logic [31:0]           slot_ext;

    assign cmd_id_ext = {10'd0, cmd.event_id};
    assign req_id_ext = {10'd0, req_reg.event_id};
    assign cmd_idx    = cmd_id_ext[IW-1:0];
    assign req_idx    = req_id_ext[IW-1:0];
    assign val_ext    = {32'd0, req_reg.value};
    assign val_use    = val_ext[VALUE_BITS-1:0];
    assign store_full = (write_count_reg == AW'(DEPTH - 1));

    // slots at or past the fill count are unwritten and are read as zero
    assign prev_val = (ls_rdata_reg < write_count_reg) ? st_rdata_reg.value : '0;

    always_comb
    begin
        status = vctr_pkg::ST_STORED;
        if (req_reg.mode == vctr_pkg::MODE_REGISTER)
        begin
            if (32'(req_id_ext) >= 32'(MAX_ID - 1))
                status = vctr_pkg::ST_REJECT;
            else if (store_full)
                status = vctr_pkg::ST_FULL;
        end
        else if (!enable_reg)
            status = vctr_pkg::ST_DISABLED;
        else if (32'(req_id_ext) >= 32'(MAX_ID))
            status = vctr_pkg::ST_REJECT;
        else if (val_use == prev_val)
            status = vctr_pkg::ST_UNCHANGED;
        else if (store_full)
            status = vctr_pkg::ST_FULL;
    end

    assign finish      = (state_reg == S_CMP) && (!rsp_valid_reg || !rsp_stall);
    assign do_store    = finish && (status == vctr_pkg::ST_STORED);
    assign count_after = do_store ? (write_count_reg + AW'(1)) : write_count_reg;
    assign slot_ext    = 32'(write_count_reg);

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // Latest-slot table: clearing pass or store write, lookup on accept
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
            latest_slot_mem[clr_idx_reg] <= '0;
        else if (do_store)
            latest_slot_mem[req_idx] <= write_count_reg;
        if ((state_reg == S_IDLE) && cmd_valid)
            ls_rdata_reg <= latest_slot_mem[cmd_idx];
    end

    // ------------------------------------------------------------------
    // Trace store: append at the fill count, read the latest slot's entry
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (do_store)
        begin
            store_mem[write_count_reg].id     <= req_reg.event_id;
            store_mem[write_count_reg].value  <=
                (req_reg.mode == vctr_pkg::MODE_REGISTER) ? '0 : val_use;
            store_mem[write_count_reg].tstamp <=
                (req_reg.mode == vctr_pkg::MODE_REGISTER) ? 64'd0 : req_reg.timestamp;
        end
        if (state_reg == S_LOOK)
            st_rdata_reg <= store_mem[ls_rdata_reg];
    end

    // ------------------------------------------------------------------
    // Sequencer, fill count and result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            write_count_reg <= '0;
            clr_idx_reg     <= '0;
            req_reg         <= '0;
            rsp_valid_reg   <= 1'b0;
            rsp_reg         <= '0;
        end
        else
        begin
            // a new result takes the slot of the one being taken
            if (rsp_valid_reg && !rsp_stall && !finish)
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + IW'(1);
                    if (clr_idx_reg == IW'(MAX_ID - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        req_reg   <= cmd;
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (finish)
                    begin
                        rsp_valid_reg    <= 1'b1;
                        rsp_reg.status   <= status;
                        rsp_reg.slot     <= do_store ? slot_ext[9:0] : 10'd0;
                        rsp_reg.now_full <= (count_after == AW'(DEPTH - 1));
                        write_count_reg  <= count_after;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // fill count never passes the last usable slot
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(write_count_reg) <= 32'(DEPTH - 1))
        else $error("write count beyond store capacity");

    // a store write is followed by a stored result
    a_store_result: assert property (@(posedge clk) disable iff (!rst_n)
        do_store |=> (rsp_valid_reg && (rsp_reg.status == vctr_pkg::ST_STORED)))
        else $error("store write without stored result");

    // the fill count moves only on a store
    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !do_store |=> $stable(write_count_reg))
        else $error("write count changed without a store");

    // only stored results carry a slot
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_reg.status != vctr_pkg::ST_STORED)) |-> (rsp_reg.slot == 10'd0))
        else $error("slot set on a non-stored result");

    // no new result is produced while the table is being cleared
    a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |=> !(rsp_valid_reg && !$past(rsp_valid_reg)))
        else $error("result produced during clearing pass");

endmodule

`default_nettype wire

// ===== bench/tb_value_change_trace_recorder_core.sv =====
// Self-checking bench for the value change trace recorder: predicted results vs. the core.
`timescale 1ns / 1ps

module tb_value_change_trace_recorder_core;

    localparam int DEPTH       = 1024;
    localparam int MAX_ID      = 64;
    localparam int VALUE_BITS  = 32;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [2:0] ENABLE_ADDR = {vctr_pkg::REG_ENABLE, 2'b00};

    typedef enum int {STALL_NONE, STALL_COIN, STALL_LONG, STALL_LIGHT} stall_style_t;

    // Trace store predictor and queue of expected results
    class trace_scoreboard;
        bit             en;
        bit [31:0]      slot_value [DEPTH];
        bit [9:0]       latest_slot [MAX_ID];
        int             fill;
        vctr_pkg::rsp_t expected_q [$];
        int             errors;

        function bit [31:0] prev_value(bit [5:0] id);
            return slot_value[latest_slot[id]];
        endfunction

        function bit store_full();
            return fill >= DEPTH - 1;
        endfunction

        // Append one event at the fill point, refused once DEPTH-1 entries are in
        function logic [2:0] append(input bit [5:0] id, input bit [31:0] val,
                                    output logic [9:0] slot);
            slot = '0;
            if (fill >= DEPTH - 1)
                return vctr_pkg::ST_FULL;
            slot_value[fill] = val;
            latest_slot[id]  = 10'(fill);
            slot = 10'(fill);
            fill++;
            return vctr_pkg::ST_STORED;
        endfunction

        // Work out the result of one accepted item
        function void note_cmd(vctr_pkg::cmd_t c);
            vctr_pkg::rsp_t r;
            logic [9:0]     s;
            r = '0;
            s = '0;
            if (c.mode == vctr_pkg::MODE_REGISTER)
            begin
                if (int'(c.event_id) < MAX_ID - 1)
                    r.status = append(c.event_id, 32'd0, s);
                else
                    r.status = vctr_pkg::ST_REJECT;
            end
            else if (!en)
                r.status = vctr_pkg::ST_DISABLED;
            else if (int'(c.event_id) >= MAX_ID)
                r.status = vctr_pkg::ST_REJECT;
            else if (c.value == prev_value(c.event_id))
                r.status = vctr_pkg::ST_UNCHANGED;
            else
                r.status = append(c.event_id, c.value, s);
            r.slot     = (r.status == vctr_pkg::ST_STORED) ? s : 10'd0;
            r.now_full = store_full();
            expected_q.push_back(r);
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_rsp(vctr_pkg::rsp_t got);
            vctr_pkg::rsp_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, actual status %0d slot %0d full %0d",
                         $time, got.status, got.slot, got.now_full);
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status)
            begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            end
            if (got.slot !== want.slot)
            begin
                errors++;
                $display("%0t: slot expected %0d actual %0d", $time, want.slot, got.slot);
            end
            if (got.now_full !== want.now_full)
            begin
                errors++;
                $display("%0t: now_full expected %0d actual %0d", $time, want.now_full,
                         got.now_full);
            end
        endfunction
    endclass

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           cmd_valid = 1'b0;
    logic           cmd_stall;
    vctr_pkg::cmd_t cmd       = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    vctr_pkg::rsp_t rsp;
    logic           psel      = 1'b0;
    logic           penable   = 1'b0;
    logic           pwrite    = 1'b0;
    logic [2:0]     paddr     = '0;
    logic [31:0]    pwdata    = '0;
    logic [31:0]    prdata;
    logic           pready;

    trace_scoreboard sb = new;

    int           cycle_count = 0;
    int           burst_left  = 0;
    stall_style_t stall_style = STALL_NONE;
    int           style_left  = 0;
    int           stall_left  = 0;

    value_change_trace_recorder_core #(
        .DEPTH      (DEPTH),
        .MAX_ID     (MAX_ID),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #4 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("value_change_trace_recorder_core: mismatch");
            $finish;
        end
    end

    // Watch both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
                sb.note_cmd(cmd);
            if (rsp_valid && !rsp_stall)
                sb.check_rsp(rsp);
        end
    end

    // Result side stall pattern; the style is picked at random and held for a random stretch
    always @(negedge clk)
    begin
        if (style_left == 0)
        begin
            stall_style = stall_style_t'($urandom_range(0, 3));
            style_left  = $urandom_range(20, 150);
        end
        style_left--;
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_stall <= 1'b1;
        end
        else
        begin
            case (stall_style)
                STALL_NONE: rsp_stall <= 1'b0;
                STALL_COIN: rsp_stall <= 1'($urandom_range(0, 1));
                STALL_LONG:
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        stall_left = $urandom_range(2, 24);
                        rsp_stall <= 1'b1;
                    end
                    else
                        rsp_stall <= 1'b0;
                end
                default: rsp_stall <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    function vctr_pkg::cmd_t mk(logic mode, logic [5:0] id, logic [31:0] val, logic [63:0] ts);
        vctr_pkg::cmd_t c;
        c.mode      = mode;
        c.event_id  = id;
        c.value     = val;
        c.timestamp = ts;
        return c;
    endfunction

    // Random item; values often repeat the id's latest value to hit the unchanged path
    function vctr_pkg::cmd_t make_random(int reg_pct);
        vctr_pkg::cmd_t c;
        int             pick;
        c.mode     = ($urandom_range(0, 99) < reg_pct) ? vctr_pkg::MODE_REGISTER
                                                       : vctr_pkg::MODE_RECORD;
        c.event_id = ($urandom_range(0, 2) == 0) ? 6'($urandom_range(0, 7))
                                                 : 6'($urandom_range(0, 63));
        pick = $urandom_range(0, 99);
        if (pick < 35)
            c.value = sb.prev_value(c.event_id);
        else if (pick < 45)
            c.value = '0;
        else if (pick < 55)
            c.value = '1;
        else if (pick < 65)
            c.value = 32'd1 << $urandom_range(0, 31);
        else
            c.value = $urandom;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            c.timestamp = '0;
        else if (pick == 1)
            c.timestamp = '1;
        else
            c.timestamp = {$urandom, $urandom};
        return c;
    endfunction

    // Offer one item and hold it until taken; valid stays high afterwards
    task automatic drive_item(vctr_pkg::cmd_t c);
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd       <= c;
        do
            @(posedge clk);
        while (cmd_stall);
    endtask

    // Send in bursts with random gaps between them
    task automatic send_item(vctr_pkg::cmd_t c);
        drive_item(c);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // Stop sending and let every expected result drain
    task automatic settle();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the enable register while idle, then read it back
    task automatic set_enable(bit v);
        settle();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ENABLE_ADDR;
        pwdata  <= {31'd0, v};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.en = v;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== {31'd0, v})
        begin
            sb.errors++;
            $display("%0t: enable readback expected %0d actual %0d", $time, v, prdata);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: disabled block, register items ignore enable
        send_item(mk(vctr_pkg::MODE_RECORD, 6'd5, 32'd7, 64'd3));
        send_item(mk(vctr_pkg::MODE_REGISTER, 6'd63, 32'd9, 64'd9));
        send_item(mk(vctr_pkg::MODE_REGISTER, 6'd10, '1, '1));
        set_enable(1'b1);
        // unregistered ids compare against slot 0
        send_item(mk(vctr_pkg::MODE_RECORD, 6'd0, 32'd0, 64'd0));
        send_item(mk(vctr_pkg::MODE_RECORD, 6'd0, '1, '1));
        send_item(mk(vctr_pkg::MODE_RECORD, 6'd1, 32'd0, 64'd5));
        send_item(mk(vctr_pkg::MODE_RECORD, 6'd1, '1, 64'd6));
        send_item(mk(vctr_pkg::MODE_RECORD, 6'd1, '1, 64'd7));
        // register: top legal id, then the rejected one
        send_item(mk(vctr_pkg::MODE_REGISTER, 6'd62, 32'd1, 64'd1));
        send_item(mk(vctr_pkg::MODE_REGISTER, 6'd63, 32'd1, 64'd1));
        send_item(mk(vctr_pkg::MODE_RECORD, 6'd62, 32'd0, 64'd8));
        send_item(mk(vctr_pkg::MODE_RECORD, 6'd63, 32'h8000_0000, 64'h8000_0000_0000_0000));
        send_item(mk(vctr_pkg::MODE_RECORD, 6'd63, 32'h7fff_ffff, 64'h7fff_ffff_ffff_ffff));
        send_item(mk(vctr_pkg::MODE_REGISTER, 6'd0, 32'h5555_5555, 64'h5555_5555_5555_5555));
        send_item(mk(vctr_pkg::MODE_RECORD, 6'd0, 32'd0, 64'haaaa_aaaa_aaaa_aaaa));
        send_item(mk(vctr_pkg::MODE_RECORD, 6'd10, 32'd1, 64'd1));
        set_enable(1'b0);
        send_item(mk(vctr_pkg::MODE_RECORD, 6'd10, 32'd2, 64'd2));
        send_item(mk(vctr_pkg::MODE_REGISTER, 6'd33, 32'd0, 64'd0));

        // Random phases across both enable settings
        for (int ph = 0; ph < 8; ph++)
        begin
            set_enable(ph != 1 && ph != 4);
            repeat (sb.en ? 110 : 25) send_item(make_random(25));
        end

        // Fill the store, then work against the full store
        set_enable(1'b1);
        while (!sb.store_full())
            send_item(make_random(70));
        repeat (80) send_item(make_random(30));
        send_item(mk(vctr_pkg::MODE_REGISTER, 6'd63, 32'd0, 64'd0));
        send_item(mk(vctr_pkg::MODE_REGISTER, 6'd0, 32'd0, 64'd0));
        set_enable(1'b0);
        repeat (20) send_item(make_random(30));
        set_enable(1'b1);
        repeat (20) send_item(make_random(30));

        settle();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("value_change_trace_recorder_core: match");
        else
            $display("value_change_trace_recorder_core: mismatch");
        $finish;
    end

endmodule

// ===== value_change_trace_recorder_core.f =====
rtl/vctr_pkg.sv
rtl/value_change_trace_recorder_core.sv
bench/tb_value_change_trace_recorder_core.sv
